// ===== src/mm3_pkg.sv =====
// Package for the 3x3 matrix multiply core: sizes, codes and shared types.
// Used by the channel interfaces and every module of the core.
package mm3_pkg;

    localparam int DIM               = 3;
    localparam int CELLS             = DIM * DIM;
    localparam int FRAC_BITS         = 16;
    localparam int ADDR_W            = 4;
    localparam int STEP_W            = 2;
    localparam int DATA_W            = 32;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // operation codes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_MULTIPLY = 1'b1;

    // matrix select codes
    localparam logic SEL_LEFT  = 1'b0;
    localparam logic SEL_RIGHT = 1'b1;

    // tag that follows a read pair down the MAC pipeline
    typedef struct packed {
        logic              valid;
        logic [STEP_W-1:0] k;
        logic [ADDR_W-1:0] idx;
        logic              last;
    } mm3_tag_t;

    // finished element from the MAC
    typedef struct packed {
        logic              final_pending;
        logic [ADDR_W-1:0] idx;
        logic [DATA_W-1:0] value;
        logic              sat;
        logic              last;
    } mm3_res_t;

endpackage

// ===== src/mm3_cmd_if.sv =====
// Command channel of the matrix multiply core: load and multiply items.
// Depends on mm3_pkg for field widths.
interface mm3_cmd_if import mm3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic              matrix_select;
    logic [ADDR_W-1:0] element_index;
    logic signed [DATA_W-1:0] element_value;

    modport source (
        output valid, operation, matrix_select, element_index, element_value,
        input  ready
    );
    modport sink (
        input  valid, operation, matrix_select, element_index, element_value,
        output ready
    );
endinterface

// ===== src/mm3_res_if.sv =====
// Result channel of the matrix multiply core: one product element per item.
// Depends on mm3_pkg for field widths.
interface mm3_res_if import mm3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_index;
    logic signed [DATA_W-1:0] result_value;
    logic              saturated;
    logic              last;

    modport source (
        output valid, result_index, result_value, saturated, last,
        input  ready
    );
    modport sink (
        input  valid, result_index, result_value, saturated, last,
        output ready
    );
endinterface

// ===== src/mm3_store.sv =====
// One 9-entry matrix store: synchronous memory, registered read port,
// per-entry valid bits so unwritten entries read as zero. Uses mm3_pkg.
module mm3_store import mm3_pkg::*; #(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [ADDR_W-1:0]               wr_addr,
    input  logic signed [ELEMENT_WIDTH-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [ADDR_W-1:0]               rd_addr,
    output logic signed [ELEMENT_WIDTH-1:0] rd_data
);

    logic signed [ELEMENT_WIDTH-1:0] mem [CELLS];
    logic [CELLS-1:0]                valid_reg;
    logic signed [ELEMENT_WIDTH-1:0] rd_data_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // valid bits stand in for the all-zero reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // registered read, held while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/mm3_mac.sv =====
// Shared multiply-accumulate unit: product register, accumulator, then
// floor shift by FRAC_BITS and saturation on the third term. Uses mm3_pkg.
module mm3_mac import mm3_pkg::*; #(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            stall,
    input  mm3_tag_t                        tag_in,
    input  logic signed [ELEMENT_WIDTH-1:0] a,
    input  logic signed [ELEMENT_WIDTH-1:0] b,
    output mm3_res_t                        res
);

    localparam int PROD_W = 2 * ELEMENT_WIDTH;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic signed [ACC_W-1:0] MAX_V =
        {{(ACC_W - ELEMENT_WIDTH + 1){1'b0}}, {(ELEMENT_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] MIN_V = ~MAX_V;

    mm3_tag_t                  tag_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_base;
    logic signed [ACC_W-1:0]   sum;
    logic signed [ACC_W-1:0]   shifted;
    logic signed [ELEMENT_WIDTH-1:0] clip;
    logic                      sat;

    // product stage tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (!stall)
        begin
            tag_reg <= tag_in;
        end
    end

    // product register, operands sign-extended to the full product width
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    // accumulate: first term restarts the sum
    always_comb
    begin
        acc_base = (tag_reg.k == '0) ? ACC_W'(0) : acc_reg;
        sum      = acc_base + ACC_W'(prod_reg);
        shifted  = sum >>> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (!stall && tag_reg.valid)
        begin
            acc_reg <= sum;
        end
    end

    // saturate to the element width
    always_comb
    begin
        sat  = 1'b0;
        clip = shifted[ELEMENT_WIDTH-1:0];
        if (shifted > MAX_V)
        begin
            sat  = 1'b1;
            clip = MAX_V[ELEMENT_WIDTH-1:0];
        end
        else if (shifted < MIN_V)
        begin
            sat  = 1'b1;
            clip = MIN_V[ELEMENT_WIDTH-1:0];
        end
    end

    assign res.final_pending = tag_reg.valid && (tag_reg.k == STEP_W'(DIM - 1));
    assign res.idx           = tag_reg.idx;
    assign res.value         = DATA_W'(clip);
    assign res.sat           = sat;
    assign res.last          = tag_reg.last;

endmodule

// ===== src/matrix_multiply_3x3_core.sv =====
// Top level of the 3x3 Q16.16 matrix multiply core.
// Instantiates two mm3_store memories and the mm3_mac unit; uses mm3_pkg.
//
// Usage:
//   cmd channel: a load item (operation 0) writes element_value into the
//   left (matrix_select 0) or right store at element_index; indices above 8
//   are dropped. A multiply item (operation 1) emits nine result items,
//   index 0..8, with last set on the ninth.
//   result[r*3+c] = sum_k right[r*3+k] * left[k*3+c], floor-shifted by 16
//   and saturated to ELEMENT_WIDTH bits, saturated flagging a clip.
// Flow:
//   A multiply runs one read pair per cycle through the single MAC unless
//   stalled; cmd ready goes high again once all its reads are issued.
//   Each result passes the store read registers, the MAC product register
//   and the output register, in index order.
// Reset: both stores read as zero, pipeline and output register empty.
// Stall: a held result freezes the read sequencer and MAC pipeline in
//   place; nothing is lost, delivery resumes when result.ready returns.
module matrix_multiply_3x3_core import mm3_pkg::*; #(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mm3_cmd_if.sink       cmd,
    mm3_res_if.source     result
);

    logic              issuing_reg, issuing_next;
    logic [STEP_W-1:0] r_reg, r_next;
    logic [STEP_W-1:0] c_reg, c_next;
    logic [STEP_W-1:0] k_reg, k_next;
    mm3_tag_t          tag_reg, tag_next;

    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_idx_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_sat_reg;
    logic              out_last_reg;

    logic              accept;
    logic              load_ok;
    logic              stall;
    logic              done;
    logic [ADDR_W-1:0] left_addr;
    logic [ADDR_W-1:0] right_addr;
    logic signed [ELEMENT_WIDTH-1:0] left_data;
    logic signed [ELEMENT_WIDTH-1:0] right_data;
    mm3_res_t          res;

    // input handshake and load decode
    assign cmd.ready = !issuing_reg;
    assign accept    = cmd.valid && cmd.ready;
    assign load_ok   = accept && (cmd.operation == OP_LOAD)
                       && (cmd.element_index < ADDR_W'(CELLS));

    // pipeline freezes while a finished element cannot enter the output reg
    assign stall = res.final_pending && out_valid_reg && !result.ready;
    assign done  = res.final_pending && !stall;

    // read addresses for the current term
    assign right_addr = ADDR_W'(r_reg * DIM + k_reg);
    assign left_addr  = ADDR_W'(k_reg * DIM + c_reg);

    mm3_store #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_ok && (cmd.matrix_select == SEL_LEFT)),
        .wr_addr (cmd.element_index),
        .wr_data (cmd.element_value[ELEMENT_WIDTH-1:0]),
        .rd_en   (!stall),
        .rd_addr (left_addr),
        .rd_data (left_data)
    );

    mm3_store #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_ok && (cmd.matrix_select == SEL_RIGHT)),
        .wr_addr (cmd.element_index),
        .wr_data (cmd.element_value[ELEMENT_WIDTH-1:0]),
        .rd_en   (!stall),
        .rd_addr (right_addr),
        .rd_data (right_data)
    );

    mm3_mac #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .stall  (stall),
        .tag_in (tag_reg),
        .a      (right_data),
        .b      (left_data),
        .res    (res)
    );

    // read sequencer: walks r, c, k and tags each read pair
    always_comb
    begin
        issuing_next = issuing_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        tag_next     = tag_reg;
        if (!stall)
        begin
            tag_next.valid = issuing_reg;
            tag_next.k     = k_reg;
            tag_next.idx   = ADDR_W'(r_reg * DIM + c_reg);
            tag_next.last  = (r_reg == STEP_W'(DIM - 1)) && (c_reg == STEP_W'(DIM - 1));
            if (issuing_reg)
            begin
                if (k_reg != STEP_W'(DIM - 1))
                begin
                    k_next = k_reg + STEP_W'(1);
                end
                else
                begin
                    k_next = '0;
                    if (c_reg != STEP_W'(DIM - 1))
                    begin
                        c_next = c_reg + STEP_W'(1);
                    end
                    else
                    begin
                        c_next = '0;
                        if (r_reg != STEP_W'(DIM - 1))
                        begin
                            r_next = r_reg + STEP_W'(1);
                        end
                        else
                        begin
                            r_next       = '0;
                            issuing_next = 1'b0;
                        end
                    end
                end
            end
        end
        if (accept && (cmd.operation == OP_MULTIPLY))
        begin
            issuing_next = 1'b1;
            r_next       = '0;
            c_next       = '0;
            k_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            r_reg       <= '0;
            c_reg       <= '0;
            k_reg       <= '0;
            tag_reg     <= '0;
        end
        else
        begin
            issuing_reg <= issuing_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            k_reg       <= k_next;
            tag_reg     <= tag_next;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (done)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_idx_reg   <= res.idx;
            out_value_reg <= res.value;
            out_sat_reg   <= res.sat;
            out_last_reg  <= res.last;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_index = out_idx_reg;
    assign result.result_value = out_value_reg;
    assign result.saturated    = out_sat_reg;
    assign result.last         = out_last_reg;

endmodule
